FILE: rtl/failed_link_pair_set_table_assert.svh
// Assertion macros used by the failed-link table checker.
`ifndef FAILED_LINK_PAIR_SET_TABLE_ASSERT_SVH
`define FAILED_LINK_PAIR_SET_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FLPST_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("flpst assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define FLPST_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("flpst assertion failed");

`endif

FILE: rtl/flpst_pkg.sv
// Types and constants of the failed-link pair set table.
`timescale 1ns / 1ps
package flpst_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int ADDR_BITS   = 16;
  localparam int FIELD_W     = 16;
  localparam int KEY_W       = (ADDR_BITS < FIELD_W) ? ADDR_BITS : FIELD_W;
  localparam int REQ_W       = 2;
  localparam int STATUS_W    = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_QUERY        = 2'd0,
    REQ_DELETE       = 2'd1,
    REQ_INSERT       = 2'd2,
    REQ_CHECK_INSERT = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_PRESENT   = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // Request word as it walks the row of slot cells.
  typedef struct packed {
    logic             active;
    req_t             req;
    logic [KEY_W-1:0] src;
    logic [KEY_W-1:0] dst;
    logic             hit;     // pair seen (or removed, for delete)
    logic             placed;  // pair written into a slot
  } tok_t;

  // Broadcast from the end of the row that settles a tentative insert.
  typedef struct packed {
    logic fin;
    logic keep;
  } cmt_t;

endpackage

FILE: rtl/failed_link_pair_set_table.sv
// Top level of the failed-link pair set table: request register, slot row, status.
`timescale 1ns / 1ps
// A request is taken when start is high and busy is low. It then walks the row of
// TABLE_DEPTH slot cells, one cell per cycle, and its status appears on out_status
// with out_valid high for one cycle, from a register behind the last cell. busy
// stays high until that cycle, so one request is in flight at a time and a new
// request can be taken only once the status of the last one is shown. The
// status cannot be held off: the receiver must take it in the cycle it is shown.
// Status codes: 0 found, deleted or inserted; 1 not found; 2 already present;
// 3 table full. Reset empties the table.
module failed_link_pair_set_table (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [flpst_pkg::REQ_W-1:0]    in_req_type,
  input  logic [flpst_pkg::FIELD_W-1:0]  in_src_addr,
  input  logic [flpst_pkg::FIELD_W-1:0]  in_dst_addr,
  output logic                           out_valid,
  output logic [flpst_pkg::STATUS_W-1:0] out_status
);
  import flpst_pkg::*;

  tok_t    tok [0:TABLE_DEPTH];
  tok_t    req_r, req_nxt;
  cmt_t    cmt;
  status_t status;
  logic    accept;
  logic    busy_r;
  logic    out_valid_r;
  status_t out_status_r;
  tok_t    last;

  assign accept = start && !busy_r;

  always_comb begin
    req_nxt        = '0;
    req_nxt.active = accept;
    req_nxt.req    = req_t'(in_req_type);
    req_nxt.src    = in_src_addr[KEY_W-1:0];
    req_nxt.dst    = in_dst_addr[KEY_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r <= '0;
    end else begin
      req_r <= req_nxt;
    end
  end

  assign tok[0] = req_r;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    flpst_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tok_in  (tok[i]),
      .cmt     (cmt),
      .tok_out (tok[i+1])
    );
  end

  assign last = tok[TABLE_DEPTH];

  always_comb begin
    cmt.fin  = last.active && (last.req == REQ_CHECK_INSERT);
    cmt.keep = !last.hit;
    unique case (last.req)
      REQ_QUERY:        status = last.hit ? ST_OK : ST_NOT_FOUND;
      REQ_DELETE:       status = last.hit ? ST_OK : ST_NOT_FOUND;
      REQ_INSERT:       status = last.placed ? ST_OK : ST_FULL;
      REQ_CHECK_INSERT: status = last.hit ? ST_PRESENT : (last.placed ? ST_OK : ST_FULL);
      default:          status = ST_NOT_FOUND;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= last.active;
      priority if (accept) begin
        busy_r <= 1'b1;
      end else if (last.active) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= status;
  end

  assign busy       = busy_r;
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;

endmodule

FILE: rtl/flpst_cell.sv
// One slot of the table: holds a pair and passes the request word to the next slot.
`timescale 1ns / 1ps
module flpst_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  flpst_pkg::tok_t tok_in,
  input  flpst_pkg::cmt_t cmt,
  output flpst_pkg::tok_t tok_out
);
  import flpst_pkg::*;

  tok_t             tok_r, tok_nxt;
  logic             valid_r, valid_nxt;
  logic             pend_r, pend_nxt;
  logic [KEY_W-1:0] src_r, src_nxt;
  logic [KEY_W-1:0] dst_r, dst_nxt;
  logic             match;
  logic             free;

  always_comb begin
    tok_nxt   = tok_in;
    valid_nxt = valid_r;
    pend_nxt  = pend_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    match     = valid_r && (src_r == tok_in.src) && (dst_r == tok_in.dst);
    free      = !valid_r && !pend_r;

    // settle a tentative check-and-insert once the whole row has been searched
    if (cmt.fin && pend_r) begin
      valid_nxt = cmt.keep;
      pend_nxt  = 1'b0;
    end

    if (tok_in.active) begin
      unique case (tok_in.req)
        REQ_QUERY: begin
          tok_nxt.hit = tok_in.hit | match;
        end
        REQ_DELETE: begin
          if (match && !tok_in.hit) begin
            valid_nxt   = 1'b0;
            tok_nxt.hit = 1'b1;
          end
        end
        REQ_INSERT: begin
          if (free && !tok_in.placed) begin
            valid_nxt      = 1'b1;
            src_nxt        = tok_in.src;
            dst_nxt        = tok_in.dst;
            tok_nxt.placed = 1'b1;
          end
        end
        REQ_CHECK_INSERT: begin
          tok_nxt.hit = tok_in.hit | match;
          // hold the pair as pending: a later slot may still hold it
          if (free && !tok_in.placed) begin
            pend_nxt       = 1'b1;
            src_nxt        = tok_in.src;
            dst_nxt        = tok_in.dst;
            tok_nxt.placed = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r   <= '0;
      valid_r <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      tok_r   <= tok_nxt;
      valid_r <= valid_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r <= src_nxt;
    dst_r <= dst_nxt;
  end

  assign tok_out = tok_r;

endmodule

FILE: rtl/flpst_checker.sv
// Port-level checks of the failed-link pair set table, bound to the top level.
`timescale 1ns / 1ps
`include "failed_link_pair_set_table_assert.svh"
module flpst_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic                           out_valid,
  input logic [flpst_pkg::STATUS_W-1:0] out_status
);
  import flpst_pkg::*;

  // a taken word keeps the block busy until its status comes out
  `FLPST_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  `FLPST_ASSERT_IMP(a_valid_idle, out_valid, !busy)
  `FLPST_ASSERT_NXT(a_single_strobe, out_valid, !out_valid)
  `FLPST_ASSERT_IMP(a_busy_ends_with_status, $fell(busy), out_valid)
  `FLPST_ASSERT_IMP(a_status_known, out_valid, !$isunknown(out_status))

endmodule

bind failed_link_pair_set_table flpst_checker u_flpst_checker (.*);

FILE: tb/tb_failed_link_pair_set_table.sv
// Self-checking testbench for the failed-link pair set table.
`timescale 1ns / 1ps
module tb_failed_link_pair_set_table;
  import flpst_pkg::*;

  localparam int RANDOM_WORDS = 1850;
  localparam int DRAIN_CYCLES = TABLE_DEPTH + 24;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int POOL_SIZE    = 8;

  localparam int FILL_ROUND  = 0;
  localparam int DRAIN_ROUND = 1;
  localparam int MIXED_ROUND = 2;

  typedef struct packed {
    req_t               kind;
    logic [FIELD_W-1:0] src;
    logic [FIELD_W-1:0] dst;
  } link_req_t;

  typedef struct packed {
    link_req_t req;
    status_t   status;
  } link_status_t;

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                start       = 1'b0;
  logic                busy;
  logic [REQ_W-1:0]    in_req_type = '0;
  logic [FIELD_W-1:0]  in_src_addr = '0;
  logic [FIELD_W-1:0]  in_dst_addr = '0;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;

  // Shadow copy of the slot store
  bit               slot_used [TABLE_DEPTH];
  logic [KEY_W-1:0] slot_src  [TABLE_DEPTH];
  logic [KEY_W-1:0] slot_dst  [TABLE_DEPTH];

  link_req_t    pending_reqs [$];
  link_status_t want_status  [$];

  int raised_count = 0;
  int taken_count  = 0;
  int idle_left    = 0;
  int burst_left   = 1;
  int cycle_count  = 0;
  int error_count  = 0;
  int peak_fill    = 0;
  int status_seen [4];

  failed_link_pair_set_table u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_req_type (in_req_type),
    .in_src_addr (in_src_addr),
    .in_dst_addr (in_dst_addr),
    .out_valid   (out_valid),
    .out_status  (out_status)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Apply one request to the shadow store and return the status it must produce.
  function automatic status_t apply_request(link_req_t r);
    int               hit;
    int               free_slot;
    int               fill;
    logic [KEY_W-1:0] s;
    logic [KEY_W-1:0] d;
    status_t          st;
    s = r.src[KEY_W-1:0];
    d = r.dst[KEY_W-1:0];
    hit = -1;
    free_slot = -1;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (slot_used[i] && hit < 0 && slot_src[i] == s && slot_dst[i] == d) hit = i;
      if (!slot_used[i] && free_slot < 0) free_slot = i;
    end
    case (r.kind)
      REQ_QUERY: begin
        st = (hit >= 0) ? ST_OK : ST_NOT_FOUND;
      end
      REQ_DELETE: begin
        if (hit >= 0) begin
          slot_used[hit] = 1'b0;
          st = ST_OK;
        end else begin
          st = ST_NOT_FOUND;
        end
      end
      default: begin
        if (r.kind == REQ_CHECK_INSERT && hit >= 0) begin
          st = ST_PRESENT;
        end else if (free_slot < 0) begin
          st = ST_FULL;
        end else begin
          slot_used[free_slot] = 1'b1;
          slot_src[free_slot] = s;
          slot_dst[free_slot] = d;
          st = ST_OK;
        end
      end
    endcase
    fill = 0;
    foreach (slot_used[i]) fill += slot_used[i];
    if (fill > peak_fill) peak_fill = fill;
    return st;
  endfunction

  task automatic add_req(input req_t k, input logic [FIELD_W-1:0] s, input logic [FIELD_W-1:0] d);
    pending_reqs.push_back('{kind: k, src: s, dst: d});
  endtask

  task automatic build_directed();
    add_req(REQ_QUERY, 16'h0000, 16'h0000);
    add_req(REQ_DELETE, 16'h0000, 16'h0000);
    add_req(REQ_INSERT, 16'hFFFF, 16'hFFFF);
    add_req(REQ_QUERY, 16'hFFFF, 16'hFFFF);
    // half matches must miss
    add_req(REQ_QUERY, 16'hFFFF, 16'h0000);
    add_req(REQ_QUERY, 16'h0000, 16'hFFFF);
    add_req(REQ_CHECK_INSERT, 16'hFFFF, 16'hFFFF);
    add_req(REQ_INSERT, 16'hFFFF, 16'hFFFF);
    // duplicates leave one copy behind per delete
    add_req(REQ_DELETE, 16'hFFFF, 16'hFFFF);
    add_req(REQ_QUERY, 16'hFFFF, 16'hFFFF);
    add_req(REQ_DELETE, 16'hFFFF, 16'hFFFF);
    add_req(REQ_DELETE, 16'hFFFF, 16'hFFFF);
    add_req(REQ_CHECK_INSERT, 16'h0000, 16'h0000);
    for (int i = 1; i < TABLE_DEPTH; i++) add_req(REQ_INSERT, 16'h5555, 16'hAAAA);
    // table is now full
    add_req(REQ_INSERT, 16'h1234, 16'h4321);
    add_req(REQ_CHECK_INSERT, 16'h1234, 16'h4321);
    add_req(REQ_CHECK_INSERT, 16'h0000, 16'h0000);
    add_req(REQ_DELETE, 16'h5555, 16'hAAAA);
    add_req(REQ_CHECK_INSERT, 16'h1234, 16'h4321);
  endtask

  task automatic build_random_traffic();
    logic [FIELD_W-1:0] pool_src [POOL_SIZE];
    logic [FIELD_W-1:0] pool_dst [POOL_SIZE];
    logic [FIELD_W-1:0] s;
    logic [FIELD_W-1:0] d;
    int                 mode;
    int                 round_len;
    int                 roll;
    int                 pick;
    int                 added;
    req_t               kind;
    added = 0;
    foreach (pool_src[i]) begin
      pool_src[i] = FIELD_W'($urandom);
      pool_dst[i] = FIELD_W'($urandom);
    end
    while (added < RANDOM_WORDS) begin
      mode = $urandom_range(FILL_ROUND, MIXED_ROUND);
      round_len = $urandom_range(30, 120);
      // replace part of the pool, keep the rest so old entries get hit again
      for (int i = 1; i < POOL_SIZE; i++) begin
        if ($urandom_range(0, 2) == 0) begin
          pool_src[i] = ($urandom_range(0, 3) == 0) ? pool_src[0] : FIELD_W'($urandom);
          pool_dst[i] = ($urandom_range(0, 3) == 0) ? pool_dst[0] : FIELD_W'($urandom);
        end
      end
      if ($urandom_range(0, 3) == 0) begin
        pool_src[POOL_SIZE-1] = $urandom_range(0, 1) ? '1 : '0;
        pool_dst[POOL_SIZE-1] = $urandom_range(0, 1) ? '1 : '0;
      end
      for (int n = 0; n < round_len && added < RANDOM_WORDS; n++) begin
        roll = $urandom_range(0, 99);
        case (mode)
          FILL_ROUND: begin
            if (roll < 10) kind = REQ_QUERY;
            else if (roll < 20) kind = REQ_DELETE;
            else if (roll < 60) kind = REQ_INSERT;
            else kind = REQ_CHECK_INSERT;
          end
          DRAIN_ROUND: begin
            if (roll < 20) kind = REQ_QUERY;
            else if (roll < 75) kind = REQ_DELETE;
            else if (roll < 85) kind = REQ_INSERT;
            else kind = REQ_CHECK_INSERT;
          end
          default: begin
            kind = req_t'(roll / 25);
          end
        endcase
        pick = $urandom_range(0, POOL_SIZE - 1);
        if ($urandom_range(0, 9) == 0) begin
          s = FIELD_W'($urandom);
          d = FIELD_W'($urandom);
        end else begin
          s = pool_src[pick];
          d = pool_dst[pick];
        end
        add_req(kind, s, d);
        added++;
      end
    end
  endtask

  // Driver: hold each word until taken, idle between bursts
  always @(negedge clk) begin
    link_req_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (taken_count == raised_count) begin
      if (idle_left > 0 || pending_reqs.size() == 0) begin
        start <= 1'b0;
        in_req_type <= REQ_W'($urandom);
        in_src_addr <= FIELD_W'($urandom);
        in_dst_addr <= FIELD_W'($urandom);
        if (idle_left > 0) idle_left <= idle_left - 1;
      end else begin
        nxt = pending_reqs.pop_front();
        start <= 1'b1;
        in_req_type <= nxt.kind;
        in_src_addr <= nxt.src;
        in_dst_addr <= nxt.dst;
        raised_count <= raised_count + 1;
        if (burst_left <= 1) begin
          if ($urandom_range(0, 4) == 0) begin
            burst_left <= $urandom_range(20, 60);
            idle_left <= 0;
          end else begin
            burst_left <= $urandom_range(1, 8);
            idle_left <= $urandom_range(0, 25);
          end
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Monitor: check each status word, predict on each accepted request
  always @(posedge clk) begin
    link_status_t head;
    link_req_t    seen;
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: no progress after %0d cycles", $time, cycle_count);
      $display("tb_failed_link_pair_set_table NOT OK");
      $finish;
    end
    if (rst_n) begin
      if (out_valid) begin
        if (want_status.size() == 0) begin
          $display("%0t: unexpected status word, expected none, actual %0d", $time, out_status);
          error_count++;
        end else begin
          head = want_status.pop_front();
          status_seen[head.status]++;
          if (out_status !== head.status) begin
            $display("%0t: %s %h/%h status mismatch: expected %s, actual %0d", $time,
                     head.req.kind.name(), head.req.src, head.req.dst,
                     head.status.name(), out_status);
            error_count++;
          end
        end
      end
      if (start && !busy) begin
        seen = '{kind: req_t'(in_req_type), src: in_src_addr, dst: in_dst_addr};
        want_status.push_back('{req: seen, status: apply_request(seen)});
        taken_count <= taken_count + 1;
      end
    end
  end

  initial begin
    build_directed();
    build_random_traffic();
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    while (pending_reqs.size() > 0 || taken_count != raised_count || want_status.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d requests in %0d cycles, peak table fill %0d of %0d", taken_count,
             cycle_count, peak_fill, TABLE_DEPTH);
    $display("status mix: ok %0d, not found %0d, already present %0d, full %0d",
             status_seen[ST_OK], status_seen[ST_NOT_FOUND], status_seen[ST_PRESENT],
             status_seen[ST_FULL]);
    if (error_count == 0) begin
      $display("tb_failed_link_pair_set_table OK");
    end else begin
      $display("tb_failed_link_pair_set_table NOT OK");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/flpst_pkg.sv
rtl/flpst_cell.sv
rtl/failed_link_pair_set_table.sv
rtl/flpst_checker.sv
tb/tb_failed_link_pair_set_table.sv
